// ===== hw/rtl/dfzs_pkg.sv =====
// Shared types, register codes and arithmetic helpers for the density field shader.
// Holds no state; the top level imports it.
`default_nettype none

package dfzs_pkg;

  typedef struct packed {
    logic        [11:0] column;
    logic        [11:0] row_index;
    logic signed [31:0] density_centre;
    logic signed [31:0] density_left;
    logic signed [31:0] density_right;
    logic signed [31:0] density_above;
    logic signed [31:0] density_below;
  } in_item_t;

  typedef struct packed {
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
    logic [15:0] alpha_out;
  } out_item_t;

  typedef enum logic [2:0] {
    REG_LIGHT,
    REG_GAINS,
    REG_CORE,
    REG_BODY,
    REG_OUTER,
    REG_WIDTH,
    REG_HEIGHT,
    REG_MODE
  } cfg_reg_t;

  localparam int SQ_ST = 16;   // square root stages, two result bits each except the last, which has one
  localparam int DV_ST = 9;    // divider stages, two quotient bits each except the last, which has one
  localparam int PO_ST = 7;    // shading and output stages

  localparam logic [23:0] NZ_Q28        = 24'd10737418;
  localparam logic [33:0] SSS_KNEE_Q28  = 34'd53687091;
  localparam logic [23:0] BODY_KNEE_Q16 = 24'd39322;
  localparam logic [15:0] DIFF_GAIN_Q16 = 16'd45875;
  localparam logic [16:0] ONE16         = 17'd65536;
  localparam logic [31:0] RECIP200      = 32'd2748779069;  // floor(2^39 / 200)
  localparam logic [15:0] HALF_INF      = 16'h7C00;

  typedef struct packed {
    logic [63:0] rem;
    logic [30:0] root;
  } sq_t;

  typedef struct packed {
    logic [46:0] rem;
    logic [16:0] quo;
  } dv_t;

  // One step of the digit-by-digit square root at result bit i.
  function automatic sq_t sqrt_step(sq_t s, int i);
    logic [63:0] t;
    sq_t         r;
    t = ({33'd0, s.root} << (i + 1)) + (64'd1 << (2 * i));
    r = s;
    if (s.rem >= t) begin
      r.rem  = s.rem - t;
      r.root = s.root | (31'd1 << i);
    end
    return r;
  endfunction

  // One restoring division step at quotient bit b.
  function automatic dv_t div_step(dv_t s, logic [30:0] den, int b);
    logic [47:0] t;
    dv_t         r;
    t = {17'd0, den} << b;
    r = s;
    if ({1'b0, s.rem} >= t) begin
      r.rem = 47'({1'b0, s.rem} - t);
      r.quo = s.quo | (17'd1 << b);
    end
    return r;
  endfunction

  function automatic logic [7:0] byte_of(logic [35:0] v);
    logic [47:0] q;
    q = (48'(v) * 48'd255 + 48'd32768) >> 16;
    return (q > 48'd255) ? 8'd255 : q[7:0];
  endfunction

  // Position of the highest set bit; zero for a zero word.
  function automatic logic [5:0] lead_one(logic [35:0] v);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 36; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

  // Q16 value to half-float bits, round to nearest even, saturate to infinity.
  function automatic logic [15:0] half_pack(logic [35:0] v, logic [5:0] p);
    logic [35:0] m;
    logic [35:0] rem;
    logic [35:0] hb;
    logic [16:0] bits;
    int          sh;
    sh = int'(p) - 10;
    m  = '0;
    if (v == '0) return 16'd0;
    if (p < 6'd2) return 16'(v << 8);
    if (sh > 0) begin
      m   = v >> sh;
      rem = v & ((36'd1 << sh) - 36'd1);
      hb  = 36'd1 << (sh - 1);
      if (rem > hb || (rem == hb && m[0])) m = m + 36'd1;
    end else begin
      m = v << (-sh);
    end
    bits = 17'((int'(p) - 2) * 1024) + {5'd0, m[11:0]};
    return (bits >= {1'b0, HALF_INF}) ? HALF_INF : bits[15:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/density_field_zoned_shader.sv =====
// Density field shader: one pixel item in, at most one shaded colour item out.
// Depends on dfzs_pkg for payload types, register codes and arithmetic helpers.
//
// Usage: present a pixel (coordinates plus five density samples) on in_item with
// in_valid; it is taken when in_ready is high. A pixel inside the shaded region
// leaves as one out_item after passing every register stage below, on an edge
// where out_ready is high. A pixel outside the region is taken and gives nothing.
// One item is taken every cycle while the output side keeps up. The 36 register
// stages are 4 front stages, 16 square root stages (radial distance and normal
// length side by side), 9 divider stages for the unit normal and a 7-stage
// shading and colour conversion tail. When out_ready is low with a result
// waiting, the whole pipeline holds and in_ready drops; nothing is lost or
// repeated. Configuration is written through cfg_write / cfg_index / cfg_data;
// the user must do so only while no pixel is in flight; the block does not check.
// Reset (rst, synchronous) empties the pipeline and loads the register defaults:
// all zero, width 64, height 3, byte output mode.
`default_nettype none

module density_field_zoned_shader #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  dfzs_pkg::in_item_t    in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output dfzs_pkg::out_item_t   out_item,
  input  logic                  cfg_write,
  input  logic [2:0]            cfg_index,
  input  logic [47:0]           cfg_data
);
  import dfzs_pkg::*;

  localparam int NST = 4 + SQ_ST + DV_ST + PO_ST;
  localparam logic [14:0] MAXW = 15'(MAX_WIDTH);
  localparam logic [14:0] MAXH = 15'(MAX_HEIGHT);

  typedef struct packed {
    logic [29:0] ax;
    logic [29:0] ay;
    logic [23:0] az;
    logic        neg_x;
    logic        neg_y;
    logic [16:0] alpha;
    logic [27:0] sss;
  } nrm_t;

  typedef struct packed {
    logic        neg_x;
    logic        neg_y;
    logic [16:0] alpha;
    logic [27:0] sss;
  } shd_t;

  // configuration
  logic [47:0] light_direction;
  logic [31:0] effect_gains;
  logic [47:0] core_colour;
  logic [47:0] body_colour;
  logic [47:0] outer_colour;
  logic [12:0] image_width;
  logic [12:0] image_height;
  logic        output_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_direction <= '0;
      effect_gains    <= '0;
      core_colour     <= '0;
      body_colour     <= '0;
      outer_colour    <= '0;
      image_width     <= 13'd64;
      image_height    <= 13'd3;
      output_mode     <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_LIGHT:  light_direction <= cfg_data;
        REG_GAINS:  effect_gains    <= cfg_data[31:0];
        REG_CORE:   core_colour     <= cfg_data;
        REG_BODY:   body_colour     <= cfg_data;
        REG_OUTER:  outer_colour    <= cfg_data;
        REG_WIDTH:  image_width     <= cfg_data[12:0];
        REG_HEIGHT: image_height    <= cfg_data[12:0];
        REG_MODE:   output_mode     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // pipeline control: everything advances together
  logic [NST-1:0] vld;
  logic           adv;
  logic           in_region;

  assign out_valid = vld[NST-1];
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], in_valid && in_region};
    end
  end

  // stage 1: region check, offsets from centre, gradients
  logic [12:0]        w_lim;
  logic [12:0]        h_lim;
  logic [13:0]        col_hi;
  logic signed [15:0] s1_dx2;
  logic signed [15:0] s1_dy2;
  logic signed [32:0] s1_nx;
  logic signed [32:0] s1_ny;
  logic signed [31:0] s1_dc;

  always_comb begin
    w_lim  = ({2'b0, image_width} > MAXW) ? MAXW[12:0] : image_width;
    h_lim  = ({2'b0, image_height} > MAXH) ? MAXH[12:0] : image_height;
    col_hi = 14'd47 + ({1'b0, w_lim - 13'd64} & 14'h3FF0);
    in_region = (h_lim >= 13'd3) && (in_item.row_index != 12'd0) &&
                ({1'b0, in_item.row_index} <= h_lim - 13'd2) &&
                (w_lim >= 13'd64) && (in_item.column >= 12'd32) &&
                ({2'b0, in_item.column} <= col_hi);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_dx2 <= $signed({3'b0, in_item.column, 1'b0}) - $signed({3'b0, w_lim});
      s1_dy2 <= $signed({3'b0, in_item.row_index, 1'b0}) - $signed({3'b0, h_lim});
      s1_nx  <= 33'(in_item.density_right) - 33'(in_item.density_left);
      s1_ny  <= 33'(in_item.density_below) - 33'(in_item.density_above);
      s1_dc  <= in_item.density_centre;
    end
  end

  // stage 2: squared radius, normal scaling, alpha and subsurface term
  logic [27:0]        s2_s;
  nrm_t               s2_n;
  logic [32:0]        ax33;
  logic [32:0]        ay33;
  logic [32:0]        axy;
  logic [1:0]         hsh;
  logic signed [31:0] dxx;
  logic signed [31:0] dyy;
  logic signed [39:0] a28;
  logic signed [33:0] sd;
  logic [47:0]        sp;
  nrm_t               n2;

  always_comb begin
    dxx  = 32'(s1_dx2) * 32'(s1_dx2);
    dyy  = 32'(s1_dy2) * 32'(s1_dy2);
    ax33 = s1_nx[32] ? 33'(-s1_nx) : 33'(s1_nx);
    ay33 = s1_ny[32] ? 33'(-s1_ny) : 33'(s1_ny);
    axy  = ax33 | ay33;
    hsh  = axy[32] ? 2'd3 : (axy[31] ? 2'd2 : (axy[30] ? 2'd1 : 2'd0));
    n2.ax    = 30'(ax33 >> hsh);
    n2.ay    = 30'(ay33 >> hsh);
    n2.az    = NZ_Q28 >> hsh;
    n2.neg_x = s1_nx[32];
    n2.neg_y = s1_ny[32];
    a28 = 40'sd268435456 - 40'(s1_dc) * 40'sd100;
    if (a28 < 0) a28 = '0;
    if (a28 > 40'sd268435456) a28 = 40'sd268435456;
    n2.alpha = a28[28:12];
    sd = $signed(SSS_KNEE_Q28) - 34'(s1_dc);
    sp = 48'(sd[31:0]) * 48'(effect_gains[31:16]);
    n2.sss = (sd > 0) ? sp[47:20] : '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_s <= dxx[27:0] + dyy[27:0];
      s2_n <= n2;
    end
  end

  // stage 3: squares of the normal
  logic [27:0] s3_s;
  nrm_t        s3_n;
  logic [59:0] s3_qx;
  logic [59:0] s3_qy;
  logic [47:0] s3_qz;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_s  <= s2_s;
      s3_n  <= s2_n;
      s3_qx <= 60'(s2_n.ax) * 60'(s2_n.ax);
      s3_qy <= 60'(s2_n.ay) * 60'(s2_n.ay);
      s3_qz <= 48'(s2_n.az) * 48'(s2_n.az);
    end
  end

  // stage 4: squared length
  logic [27:0] s4_s;
  nrm_t        s4_n;
  logic [61:0] s4_nn;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_s  <= s3_s;
      s4_n  <= s3_n;
      s4_nn <= 62'(s3_qx) + 62'(s3_qy) + 62'(s3_qz);
    end
  end

  // square root stages: radius (Q16 of sqrt S) and normal length in parallel
  sq_t  sqr      [SQ_ST];
  sq_t  sqn      [SQ_ST];
  nrm_t sqc      [SQ_ST];
  sq_t  sqr_next [SQ_ST];
  sq_t  sqn_next [SQ_ST];

  always_comb begin
    sq_t r0;
    sq_t n0;
    r0.rem  = 64'(s4_s) << 32;
    r0.root = '0;
    n0.rem  = 64'(s4_nn);
    n0.root = '0;
    r0 = sqrt_step(r0, 30);
    n0 = sqrt_step(n0, 30);
    sqr_next[0] = sqrt_step(r0, 29);
    sqn_next[0] = sqrt_step(n0, 29);
    for (int k = 1; k < SQ_ST; k++) begin
      r0 = sqrt_step(sqr[k-1], 30 - 2 * k);
      n0 = sqrt_step(sqn[k-1], 30 - 2 * k);
      if (29 - 2 * k >= 0) begin
        r0 = sqrt_step(r0, 29 - 2 * k);
        n0 = sqrt_step(n0, 29 - 2 * k);
      end
      sqr_next[k] = r0;
      sqn_next[k] = n0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sqr <= sqr_next;
      sqn <= sqn_next;
      sqc[0] <= s4_n;
      for (int k = 1; k < SQ_ST; k++) sqc[k] <= sqc[k-1];
    end
  end

  // divider stages: unit normal components, len in the denominator
  dv_t         dvx      [DV_ST];
  dv_t         dvy      [DV_ST];
  dv_t         dvz      [DV_ST];
  logic [30:0] dvl      [DV_ST];
  shd_t        dvc      [DV_ST];
  dv_t         dvx_next [DV_ST];
  dv_t         dvy_next [DV_ST];
  dv_t         dvz_next [DV_ST];
  shd_t        c_in;

  always_comb begin
    dv_t         x0;
    dv_t         y0;
    dv_t         z0;
    logic [30:0] den;
    nrm_t        ns;
    ns  = sqc[SQ_ST-1];
    den = sqn[SQ_ST-1].root;
    c_in.neg_x = ns.neg_x;
    c_in.neg_y = ns.neg_y;
    c_in.alpha = ns.alpha;
    c_in.sss   = ns.sss;
    x0.rem = {1'b0, ns.ax, 16'd0};
    y0.rem = {1'b0, ns.ay, 16'd0};
    z0.rem = {7'd0, ns.az, 16'd0};
    x0.quo = '0;
    y0.quo = '0;
    z0.quo = '0;
    x0 = div_step(x0, den, 16);
    y0 = div_step(y0, den, 16);
    z0 = div_step(z0, den, 16);
    dvx_next[0] = div_step(x0, den, 15);
    dvy_next[0] = div_step(y0, den, 15);
    dvz_next[0] = div_step(z0, den, 15);
    for (int m = 1; m < DV_ST; m++) begin
      x0 = div_step(dvx[m-1], dvl[m-1], 16 - 2 * m);
      y0 = div_step(dvy[m-1], dvl[m-1], 16 - 2 * m);
      z0 = div_step(dvz[m-1], dvl[m-1], 16 - 2 * m);
      if (15 - 2 * m >= 0) begin
        x0 = div_step(x0, dvl[m-1], 15 - 2 * m);
        y0 = div_step(y0, dvl[m-1], 15 - 2 * m);
        z0 = div_step(z0, dvl[m-1], 15 - 2 * m);
      end
      dvx_next[m] = x0;
      dvy_next[m] = y0;
      dvz_next[m] = z0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dvx <= dvx_next;
      dvy <= dvy_next;
      dvz <= dvz_next;
      dvl[0] <= sqn[SQ_ST-1].root;
      dvc[0] <= c_in;
      for (int m = 1; m < DV_ST; m++) begin
        dvl[m] <= dvl[m-1];
        dvc[m] <= dvc[m-1];
      end
    end
  end

  // radial zone masks and colour mix, alongside the divider
  logic [30:0] rd0_r;
  logic [62:0] rd0_prod;
  logic [23:0] rd1_nd;
  logic [16:0] rd2_core;
  logic [16:0] rd2_f;
  logic [16:0] rd3_core;
  logic [16:0] rd3_body;
  logic [16:0] rd4_core;
  logic [16:0] rd4_body;
  logic [16:0] rd4_outer;
  logic [32:0] rd5_pc [3];
  logic [32:0] rd5_pb [3];
  logic [32:0] rd5_po [3];
  logic [20:0] rd6_mix [3];
  logic [20:0] rd7_mix [3];
  logic [20:0] rd8_mix [3];
  logic [23:0] q_est;
  logic [31:0] q_rem;
  logic [26:0] nd5;
  logic [23:0] nd_knee;
  logic [33:0] body_p;
  logic [17:0] cb_sum;
  logic [34:0] mix_sum [3];

  always_comb begin
    q_est   = rd0_prod[62:39];
    q_rem   = {1'b0, rd0_r} - 32'(q_est) * 32'd200;
    nd5     = 27'(rd1_nd) * 27'd5;
    nd_knee = (rd1_nd > BODY_KNEE_Q16) ? rd1_nd - BODY_KNEE_Q16 : '0;
    body_p  = 34'(ONE16 - rd2_core) * 34'(rd2_f);
    cb_sum  = 18'(rd3_core) + 18'(rd3_body);
    for (int k = 0; k < 3; k++) begin
      mix_sum[k] = 35'(rd5_pc[k]) + 35'(rd5_pb[k]) + 35'(rd5_po[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd0_r     <= sqr[SQ_ST-1].root;
      rd0_prod  <= 63'(sqr[SQ_ST-1].root) * 63'(RECIP200);
      rd1_nd    <= q_est + ((q_rem >= 32'd200) ? 24'd1 : 24'd0);
      rd2_core  <= (nd5 >= 27'(ONE16)) ? '0 : ONE16 - nd5[16:0];
      rd2_f     <= (nd_knee >= 24'(ONE16)) ? '0 : ONE16 - nd_knee[16:0];
      rd3_core  <= rd2_core;
      rd3_body  <= body_p[32:16];
      rd4_core  <= rd3_core;
      rd4_body  <= rd3_body;
      rd4_outer <= (cb_sum >= 18'(ONE16)) ? '0 : ONE16 - cb_sum[16:0];
      for (int k = 0; k < 3; k++) begin
        rd5_pc[k]  <= 33'(rd4_core)  * 33'(core_colour[16*k +: 16]);
        rd5_pb[k]  <= 33'(rd4_body)  * 33'(body_colour[16*k +: 16]);
        rd5_po[k]  <= 33'(rd4_outer) * 33'(outer_colour[16*k +: 16]);
        rd6_mix[k] <= mix_sum[k][34:14];
        rd7_mix[k] <= rd6_mix[k];
        rd8_mix[k] <= rd7_mix[k];
      end
    end
  end

  // shading tail
  logic [16:0]        uz_c;
  logic signed [17:0] sx;
  logic signed [17:0] sy;
  logic signed [33:0] p1_px;
  logic signed [33:0] p1_py;
  logic signed [33:0] p1_pz;
  logic [32:0]        p1_fp;
  logic [16:0]        p1_alpha;
  logic [27:0]        p1_sss;
  logic [20:0]        p1_mix [3];

  always_comb begin
    uz_c = (dvz[DV_ST-1].quo > ONE16) ? ONE16 : dvz[DV_ST-1].quo;
    sx   = dvc[DV_ST-1].neg_x ? -$signed({1'b0, dvx[DV_ST-1].quo})
                              :  $signed({1'b0, dvx[DV_ST-1].quo});
    sy   = dvc[DV_ST-1].neg_y ? -$signed({1'b0, dvy[DV_ST-1].quo})
                              :  $signed({1'b0, dvy[DV_ST-1].quo});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_px    <= 34'(sx) * 34'($signed(light_direction[15:0]));
      p1_py    <= 34'(sy) * 34'($signed(light_direction[31:16]));
      p1_pz    <= 34'($signed({1'b0, uz_c})) * 34'($signed(light_direction[47:32]));
      p1_fp    <= 33'(ONE16 - uz_c) * 33'(effect_gains[15:0]);
      p1_alpha <= dvc[DV_ST-1].alpha;
      p1_sss   <= dvc[DV_ST-1].sss;
      p1_mix   <= rd8_mix;
    end
  end

  logic signed [35:0] dot;
  logic [21:0]        p2_diff;
  logic [24:0]        p2_fres;
  logic [16:0]        p2_alpha;
  logic [27:0]        p2_sss;
  logic [20:0]        p2_mix [3];

  assign dot = 36'(p1_px) + 36'(p1_py) + 36'(p1_pz);

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_diff  <= (dot > 0) ? dot[35:14] : '0;
      p2_fres  <= p1_fp[32:8];
      p2_alpha <= p1_alpha;
      p2_sss   <= p1_sss;
      p2_mix   <= p1_mix;
    end
  end

  logic [37:0] dg;
  logic [29:0] p3_sum;
  logic [16:0] p3_alpha;
  logic [20:0] p3_mix [3];

  assign dg = 38'(p2_diff) * 38'(DIFF_GAIN_Q16);

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_sum   <= 30'(dg[37:16]) + 30'(p2_fres) + 30'(p2_sss);
      p3_alpha <= p2_alpha;
      p3_mix   <= p2_mix;
    end
  end

  logic [46:0] ip;
  logic [30:0] p4_inten;
  logic [16:0] p4_alpha;
  logic [20:0] p4_mix [3];

  assign ip = 47'(p3_sum) * 47'(p3_alpha);

  always_ff @(posedge clk) begin
    if (adv) begin
      p4_inten <= ip[46:16];
      p4_alpha <= p3_alpha;
      p4_mix   <= p3_mix;
    end
  end

  logic [51:0] cp [3];
  logic [35:0] p5_chan [3];
  logic [16:0] p5_alpha;

  always_comb begin
    for (int k = 0; k < 3; k++) cp[k] = 52'(p4_inten) * 52'(p4_mix[k]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) p5_chan[k] <= cp[k][51:16];
      p5_alpha <= p4_alpha;
    end
  end

  // byte conversion and leading-one search ahead of the half-float pack
  logic [7:0]  p6_byte [3];
  logic [5:0]  p6_lead [4];
  logic [35:0] p6_chan [3];
  logic [16:0] p6_alpha;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        p6_byte[k] <= byte_of(p5_chan[k]);
        p6_lead[k] <= lead_one(p5_chan[k]);
      end
      p6_lead[3] <= lead_one(36'(p5_alpha));
      p6_chan    <= p5_chan;
      p6_alpha   <= p5_alpha;
    end
  end

  out_item_t res;

  always_comb begin
    if (output_mode) begin
      res.red_out   = half_pack(p6_chan[0], p6_lead[0]);
      res.green_out = half_pack(p6_chan[1], p6_lead[1]);
      res.blue_out  = half_pack(p6_chan[2], p6_lead[2]);
      res.alpha_out = half_pack(36'(p6_alpha), p6_lead[3]);
    end else begin
      res.red_out   = {8'd0, p6_byte[0]};
      res.green_out = {8'd0, p6_byte[1]};
      res.blue_out  = {8'd0, p6_byte[2]};
      res.alpha_out = 16'd255;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item <= res;
    end
  end

endmodule

`default_nettype wire

// ===== dv/dfzs_checker.sv =====
// Checker for the density field shader: watches the pixel and colour channels,
// predicts each shaded colour item and compares it with the one that comes out.
// Depends on dfzs_pkg for the payload types and register codes.
`default_nettype none

module dfzs_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  dfzs_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_ready,
  input  dfzs_pkg::out_item_t out_item,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [47:0]         cfg_data,
  output int                  fail_count,
  output int                  colours_pending
);
  import dfzs_pkg::*;

  logic [47:0] light_q, core_q, body_q, outer_q;
  logic [31:0] gains_q;
  logic [12:0] width_q, height_q;
  logic        mode_q;
  out_item_t   colour_queue[$];

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] to_half(longint unsigned v);
    int p, sh;
    longint unsigned m, rm, hb, bits;
    if (v == 0) return 16'd0;
    p = 63;
    while (((v >> p) & 1) == 0) p--;
    if (p < 2) return 16'(v << 8);
    sh = p - 10;
    if (sh > 0) begin
      m  = v >> sh;
      rm = v & ((64'd1 << sh) - 1);
      hb = 64'd1 << (sh - 1);
      if (rm > hb || (rm == hb && m[0])) m++;
    end else begin
      m = v << (-sh);
    end
    bits = longint'(p - 2) * 1024 + m;
    return bits >= 64'h7C00 ? 16'h7C00 : 16'(bits);
  endfunction

  function automatic logic [15:0] to_byte(longint unsigned v);
    longint unsigned q;
    q = (v * 255 + 32768) >> 16;
    return q > 255 ? 16'd255 : 16'(q);
  endfunction

  function automatic longint unsigned part(logic [47:0] r, int k);
    return longint'(r[16*k +: 16]);
  endfunction

  // Return 1 and the colour when the pixel lies in the shaded region.
  function automatic bit shade_pixel(in_item_t px, output out_item_t res);
    longint unsigned w, h, col, row, s, nd, t, core, body, outer, f;
    longint unsigned ax, ay, az, len, ux, uy, uz, alpha, fres, sss, diff, sum, inten, mix;
    longint unsigned chan[3];
    longint dc, nx, ny, dx2, dy2, dot, a28, sd;
    w = width_q > 4096 ? 4096 : width_q;
    h = height_q > 4096 ? 4096 : height_q;
    col = px.column;
    row = px.row_index;
    res = '0;
    if (h < 3 || row < 1 || row > h - 2) return 0;
    if (w < 64 || col < 32 || col > 32 + ((w - 64) / 16) * 16 + 15) return 0;
    dc = px.density_centre;
    nx = longint'(px.density_right) - longint'(px.density_left);
    ny = longint'(px.density_below) - longint'(px.density_above);
    dx2 = 2 * longint'(col) - longint'(w);
    dy2 = 2 * longint'(row) - longint'(h);
    s = dx2 * dx2 + dy2 * dy2;
    nd = int_sqrt(s << 32) / 200;
    t = 5 * nd;
    core = t >= 65536 ? 0 : 65536 - t;
    t = nd > 39322 ? nd - 39322 : 0;
    f = t >= 65536 ? 0 : 65536 - t;
    body = ((65536 - core) * f) >> 16;
    outer = core + body >= 65536 ? 0 : 65536 - (core + body);
    ax = nx < 0 ? -nx : nx;
    ay = ny < 0 ? -ny : ny;
    az = 10737418;
    while (ax >= (64'd1 << 30) || ay >= (64'd1 << 30)) begin
      ax >>= 1;
      ay >>= 1;
      az >>= 1;
    end
    len = int_sqrt(ax * ax + ay * ay + az * az);
    ux = (ax << 16) / len;
    uy = (ay << 16) / len;
    uz = (az << 16) / len;
    if (uz > 65536) uz = 65536;
    dot = (nx < 0 ? -longint'(ux) : longint'(ux)) * longint'($signed(light_q[15:0]))
        + (ny < 0 ? -longint'(uy) : longint'(uy)) * longint'($signed(light_q[31:16]))
        + longint'(uz) * longint'($signed(light_q[47:32]));
    diff = dot > 0 ? longint'(dot) >> 14 : 0;
    fres = ((65536 - uz) * gains_q[15:0]) >> 8;
    sd = 53687091 - dc;
    sss = sd > 0 ? (longint'(sd) * gains_q[31:16]) >> 20 : 0;
    a28 = 268435456 - 100 * dc;
    if (a28 < 0) a28 = 0;
    if (a28 > 268435456) a28 = 268435456;
    alpha = a28 >> 12;
    sum = ((diff * 45875) >> 16) + fres + sss;
    inten = (sum * alpha) >> 16;
    for (int k = 0; k < 3; k++) begin
      mix = (core * part(core_q, k) + body * part(body_q, k) + outer * part(outer_q, k)) >> 14;
      chan[k] = (inten * mix) >> 16;
    end
    if (mode_q) begin
      res = '{to_half(chan[0]), to_half(chan[1]), to_half(chan[2]), to_half(alpha)};
    end else begin
      res = '{to_byte(chan[0]), to_byte(chan[1]), to_byte(chan[2]), 16'd255};
    end
    return 1;
  endfunction

  assign colours_pending = colour_queue.size();

  always_ff @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      light_q <= '0; gains_q <= '0; core_q <= '0; body_q <= '0; outer_q <= '0;
      width_q <= 13'd64; height_q <= 13'd3; mode_q <= 1'b0;
      colour_queue.delete();
      fail_count <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_LIGHT:  light_q  <= cfg_data;
          REG_GAINS:  gains_q  <= cfg_data[31:0];
          REG_CORE:   core_q   <= cfg_data;
          REG_BODY:   body_q   <= cfg_data;
          REG_OUTER:  outer_q  <= cfg_data;
          REG_WIDTH:  width_q  <= cfg_data[12:0];
          REG_HEIGHT: height_q <= cfg_data[12:0];
          REG_MODE:   mode_q   <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready && shade_pixel(in_item, want)) colour_queue.push_back(want);
      if (out_valid && out_ready) begin
        if (colour_queue.size() == 0) begin
          if (fail_count < 10) $display("unexpected colour item %h", out_item);
          fail_count <= fail_count + 1;
        end else begin
          want = colour_queue.pop_front();
          if (want !== out_item) begin
            if (fail_count < 10)
              $display("colour mismatch: want r %h g %h b %h a %h, got r %h g %h b %h a %h",
                       want.red_out, want.green_out, want.blue_out, want.alpha_out,
                       out_item.red_out, out_item.green_out, out_item.blue_out,
                       out_item.alpha_out);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

`default_nettype wire

// ===== dv/tb_density_field_zoned_shader.sv =====
// Testbench top for the density field shader: reset, register phases, pixel
// stimulus with random stalls, and the verdict. Depends on dfzs_pkg and dfzs_checker.
`default_nettype none

module tb_density_field_zoned_shader;
  import dfzs_pkg::*;

  localparam int DRAIN_CYCLES = 80;
  localparam int STALL_LIMIT  = 5000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0, in_ready;
  in_item_t    in_item = '0;
  logic        out_valid, out_ready = 1'b0;
  out_item_t   out_item;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [47:0] cfg_data = '0;
  int          fail_count, colours_pending;
  int          quiet_cycles = 0;
  bit          steady = 1'b0;
  logic [12:0] cur_w = 13'd64, cur_h = 13'd3;

  always #4 clk = ~clk;

  density_field_zoned_shader dut (.*);

  dfzs_checker checker_i (.*);

  // Watchdog on cycles without any accepted item.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver stalls about a fifth of the time, except in the steady stretch.
  always @(posedge clk) out_ready <= steady || ($urandom_range(99) >= 21);

  // Hold the enable for one edge, then drop it and wait with it low before returning.
  task automatic write_reg(cfg_reg_t idx, logic [47:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == REG_WIDTH) cur_w = val[12:0];
    if (idx == REG_HEIGHT) cur_h = val[12:0];
    @(posedge clk);
  endtask

  task automatic drain;
    while (colours_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_pixel(in_item_t px);
    if (!steady) begin
      while ($urandom_range(99) < 21) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_item  <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_density();
    case ($urandom_range(4))
      0: return $urandom;
      1: return 32'($signed($urandom_range(8000000)) - 4000000);
      2: return 32'($urandom_range(3000000));
      default: return 32'($signed($urandom_range(60000000)) - 30000000);
    endcase
  endfunction

  function automatic in_item_t rand_pixel();
    in_item_t px;
    px.density_centre = rand_density();
    px.density_left   = rand_density();
    px.density_right  = rand_density();
    px.density_above  = rand_density();
    px.density_below  = rand_density();
    if ($urandom_range(9) == 0) begin
      px.column = 12'($urandom);
      px.row_index = 12'($urandom);
    end else begin
      // Mostly in the image, with edges reached now and then.
      px.column = 12'($urandom_range((cur_w > 4096 ? 4095 : cur_w - 1), 0));
      px.row_index = 12'($urandom_range((cur_h > 4096 ? 4095 : cur_h - 1), 0));
    end
    return px;
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      steady = (i >= count / 3) && (i < count / 3 + 40);
      send_pixel(rand_pixel());
    end
    in_valid <= 1'b0;
    steady = 1'b0;
    drain();
  endtask

  task automatic random_regs();
    write_reg(REG_LIGHT, 48'({$urandom, $urandom}));
    write_reg(REG_GAINS, {16'd0, $urandom});
    write_reg(REG_CORE, 48'({$urandom, $urandom}));
    write_reg(REG_BODY, 48'({$urandom, $urandom}));
    write_reg(REG_OUTER, 48'({$urandom, $urandom}));
    write_reg(REG_MODE, 48'($urandom_range(1)));
  endtask

  initial begin
    in_item_t px;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: defaults, the low region edges and columns beyond the region, extremes of densities.
    write_reg(REG_LIGHT, {16'h2000, 16'hE000, 16'h4000});
    write_reg(REG_GAINS, {16'd0, 16'h0180, 16'h0100});
    write_reg(REG_CORE, {16'h4000, 16'h2000, 16'h1000});
    write_reg(REG_BODY, {16'h1000, 16'h4000, 16'h2000});
    write_reg(REG_OUTER, {16'hFFFF, 16'h0000, 16'h8000});
    for (int k = 0; k < 12; k++) begin
      px = '0;
      px.row_index = (k % 3 == 0) ? 12'd0 : 12'd1;
      px.column = 12'((k < 4) ? 31 + k : (k < 8 ? 46 + k : 4095));
      px.density_centre = (k % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      px.density_left   = (k % 4 == 1) ? 32'h8000_0000 : 32'h0;
      px.density_right  = (k % 4 == 1) ? 32'h7FFF_FFFF : 32'h0;
      px.density_above  = (k % 4 == 2) ? 32'h7FFF_FFFF : 32'h0;
      px.density_below  = (k % 4 == 2) ? 32'h8000_0000 : 32'h0;
      if (k == 5) px.density_centre = 32'd0;
      send_pixel(px);
    end
    in_valid <= 1'b0;
    drain();
    write_reg(REG_MODE, 48'd1);
    for (int k = 0; k < 8; k++) begin
      px = rand_pixel();
      px.row_index = 12'd1;
      px.column = 12'd32 + 12'(k * 4);
      if (k == 0) px.density_centre = 32'h0;
      if (k == 1) px.density_centre = 32'h8000_0000;
      send_pixel(px);
    end
    in_valid <= 1'b0;
    drain();

    // Extreme and odd image sizes, including ones that shade nothing.
    write_reg(REG_WIDTH, 48'd4096);
    write_reg(REG_HEIGHT, 48'd4096);
    random_regs();
    random_phase(150);
    write_reg(REG_WIDTH, 48'h1FFF);
    write_reg(REG_HEIGHT, 48'h1FFF);
    random_regs();
    random_phase(100);
    write_reg(REG_WIDTH, 48'd63);
    write_reg(REG_HEIGHT, 48'd2);
    random_phase(20);
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(REG_WIDTH, 48'($urandom_range(200, 64)));
      write_reg(REG_HEIGHT, 48'($urandom_range(120, 3)));
      random_regs();
      random_phase(100);
    end

    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

`default_nettype wire
